/* rtl/core/dgd_pkg.sv */
// Shared types and constants for the drag gesture detector.
package dgd_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int POINTER_ID_WIDTH_DEF = 4;

  localparam int ACTION_W        = 2;
  localparam int BUTTON_W        = 3;
  localparam int GESTURE_PHASE_W = 2;
  localparam int THRESHOLD_W     = 17;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 17'd25;
  localparam logic [BUTTON_W-1:0]    BUTTON_LEFT   = 3'd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_DRAGGING = 2'd2
  } phase_t;

  typedef enum logic [GESTURE_PHASE_W-1:0] {
    GP_STARTED  = 2'd0,
    GP_UPDATED  = 2'd1,
    GP_FINISHED = 2'd2
  } gesture_t;

endpackage

/* rtl/core/drag_gesture_detector.sv */
// Drag gesture detector top level: input register, tracker, result register.
//
// Takes one pointer event request per clock cycle unless a stalled result
// register holds it back, and gives a started, updated or finished result when
// the tracked pointer drags past the threshold, moves on, or is released. An
// event sits in the input register while the tracker works on it
// combinationally; any result is then loaded into the result register, which
// drives out_tvalid until the sink takes it. The sustained rate is one event
// per cycle while the result register is not stalled; a stalled result register
// holds back only events that give a result, and events that give none drain
// at once. The threshold is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while no event is in flight, as the block itself does not
// enforce this; it resets to 25.
module drag_gesture_detector
  import dgd_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int POINTER_ID_WIDTH = POINTER_ID_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // action, button, pointer_id, pos_x, pos_y (from bit 0 up), zero padded
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [((ACTION_W + BUTTON_W + POINTER_ID_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0]
                                 in_tdata,
  // gesture_phase, start_x, start_y, cur_x, cur_y, delta_x, delta_y
  // (from bit 0 up), zero padded
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((GESTURE_PHASE_W + 6 * COORD_WIDTH + 2 + 7) / 8) * 8 - 1:0]
                                 out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [THRESHOLD_W-1:0] cfg_wr_data
);

  localparam int IN_TDATA_W  =
    ((ACTION_W + BUTTON_W + POINTER_ID_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((GESTURE_PHASE_W + 6 * COORD_WIDTH + 2 + 7) / 8) * 8;

  logic                        item_vld, advance, slot_free;
  logic [ACTION_W-1:0]         item_action;
  logic [BUTTON_W-1:0]         item_button;
  logic [POINTER_ID_WIDTH-1:0] item_pointer_id;
  logic [COORD_WIDTH-1:0]      item_pos_x, item_pos_y;

  logic                        res_vld;
  logic [GESTURE_PHASE_W-1:0]  res_phase;
  logic [COORD_WIDTH-1:0]      res_start_x, res_start_y, res_cur_x, res_cur_y;
  logic [COORD_WIDTH:0]        res_delta_x, res_delta_y;

  // event leaves the input register when it gives no result or the result
  // register can take one this cycle
  assign advance = item_vld && (!res_vld || slot_free);

  dgd_in_reg #(
    .COORD_WIDTH      (COORD_WIDTH),
    .POINTER_ID_WIDTH (POINTER_ID_WIDTH),
    .IN_TDATA_W       (IN_TDATA_W)
  ) u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .advance         (advance),
    .item_vld        (item_vld),
    .item_action     (item_action),
    .item_button     (item_button),
    .item_pointer_id (item_pointer_id),
    .item_pos_x      (item_pos_x),
    .item_pos_y      (item_pos_y)
  );

  dgd_tracker #(
    .COORD_WIDTH      (COORD_WIDTH),
    .POINTER_ID_WIDTH (POINTER_ID_WIDTH)
  ) u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .advance         (advance),
    .item_action     (item_action),
    .item_button     (item_button),
    .item_pointer_id (item_pointer_id),
    .item_pos_x      (item_pos_x),
    .item_pos_y      (item_pos_y),
    .res_vld         (res_vld),
    .res_phase       (res_phase),
    .res_start_x     (res_start_x),
    .res_start_y     (res_start_y),
    .res_cur_x       (res_cur_x),
    .res_cur_y       (res_cur_y),
    .res_delta_x     (res_delta_x),
    .res_delta_y     (res_delta_y)
  );

  dgd_out_reg #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (advance && res_vld),
    .res_phase   (res_phase),
    .res_start_x (res_start_x),
    .res_start_y (res_start_y),
    .res_cur_x   (res_cur_x),
    .res_cur_y   (res_cur_y),
    .res_delta_x (res_delta_x),
    .res_delta_y (res_delta_y),
    .slot_free   (slot_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

/* rtl/core/dgd_in_reg.sv */
// Input register: holds one pointer event request and unpacks its fields.
module dgd_in_reg
  import dgd_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int POINTER_ID_WIDTH = POINTER_ID_WIDTH_DEF,
  parameter int IN_TDATA_W       = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_TDATA_W-1:0]       in_tdata,
  input  logic                        advance,
  output logic                        item_vld,
  output logic [ACTION_W-1:0]         item_action,
  output logic [BUTTON_W-1:0]         item_button,
  output logic [POINTER_ID_WIDTH-1:0] item_pointer_id,
  output logic [COORD_WIDTH-1:0]      item_pos_x,
  output logic [COORD_WIDTH-1:0]      item_pos_y
);

  localparam int PID_LO = ACTION_W + BUTTON_W;
  localparam int PX_LO  = PID_LO + POINTER_ID_WIDTH;
  localparam int PY_LO  = PX_LO + COORD_WIDTH;
  localparam int IN_BITS = PY_LO + COORD_WIDTH;

  logic               vld_r, vld_nxt;
  logic [IN_BITS-1:0] data_r;
  logic               load;

  assign in_tready = !vld_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata[IN_BITS-1:0];
    end
  end

  assign item_vld        = vld_r;
  assign item_action     = data_r[ACTION_W-1:0];
  assign item_button     = data_r[PID_LO-1:ACTION_W];
  assign item_pointer_id = data_r[PX_LO-1:PID_LO];
  assign item_pos_x      = data_r[PY_LO-1:PX_LO];
  assign item_pos_y      = data_r[IN_BITS-1:PY_LO];

endmodule

/* rtl/core/dgd_tracker.sv */
// Gesture state machine, tracked pointer, positions and result forming.
module dgd_tracker
  import dgd_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int POINTER_ID_WIDTH = POINTER_ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [THRESHOLD_W-1:0]      cfg_wr_data,
  input  logic                        advance,
  input  logic [ACTION_W-1:0]         item_action,
  input  logic [BUTTON_W-1:0]         item_button,
  input  logic [POINTER_ID_WIDTH-1:0] item_pointer_id,
  input  logic [COORD_WIDTH-1:0]      item_pos_x,
  input  logic [COORD_WIDTH-1:0]      item_pos_y,
  output logic                        res_vld,
  output logic [GESTURE_PHASE_W-1:0]  res_phase,
  output logic [COORD_WIDTH-1:0]      res_start_x,
  output logic [COORD_WIDTH-1:0]      res_start_y,
  output logic [COORD_WIDTH-1:0]      res_cur_x,
  output logic [COORD_WIDTH-1:0]      res_cur_y,
  output logic [COORD_WIDTH:0]        res_delta_x,
  output logic [COORD_WIDTH:0]        res_delta_y
);

  localparam int DIST_W = COORD_WIDTH + 2;
  localparam int CMP_W  = (DIST_W > THRESHOLD_W) ? DIST_W : THRESHOLD_W;

  phase_t                      phase_r, phase_nxt;
  logic [THRESHOLD_W-1:0]      thr_r;
  logic [POINTER_ID_WIDTH-1:0] track_id_r;
  logic [COORD_WIDTH-1:0]      start_x_r, start_y_r, last_x_r, last_y_r;

  logic                        capture_start, capture_last;
  logic                        same;
  logic signed [COORD_WIDTH:0] px_e, py_e, sx_e, sy_e, lx_e, ly_e;
  logic signed [COORD_WIDTH:0] ds_x, ds_y, dl_x, dl_y;
  logic [COORD_WIDTH:0]        mag_x, mag_y;
  logic [DIST_W-1:0]           man_dist;
  logic                        past_thr;
  gesture_t                    kind;

  assign same = (item_pointer_id == track_id_r);

  assign px_e = {item_pos_x[COORD_WIDTH-1], item_pos_x};
  assign py_e = {item_pos_y[COORD_WIDTH-1], item_pos_y};
  assign sx_e = {start_x_r[COORD_WIDTH-1], start_x_r};
  assign sy_e = {start_y_r[COORD_WIDTH-1], start_y_r};
  assign lx_e = {last_x_r[COORD_WIDTH-1], last_x_r};
  assign ly_e = {last_y_r[COORD_WIDTH-1], last_y_r};

  assign ds_x = px_e - sx_e;
  assign ds_y = py_e - sy_e;
  assign dl_x = px_e - lx_e;
  assign dl_y = py_e - ly_e;

  // |d| fits in COORD_WIDTH+1 bits unsigned
  assign mag_x    = ds_x[COORD_WIDTH] ? (-ds_x) : ds_x;
  assign mag_y    = ds_y[COORD_WIDTH] ? (-ds_y) : ds_y;
  assign man_dist = {1'b0, mag_x} + {1'b0, mag_y};
  assign past_thr = CMP_W'(man_dist) > CMP_W'(thr_r);

  always_comb begin
    phase_nxt     = phase_r;
    capture_start = 1'b0;
    capture_last  = 1'b0;
    res_vld       = 1'b0;
    kind          = GP_UPDATED;
    case (action_t'(item_action))
      ACT_PRESS: begin
        if (phase_r == PH_IDLE && item_button == BUTTON_LEFT) begin
          phase_nxt     = PH_PRESSED;
          capture_start = 1'b1;
          capture_last  = 1'b1;
        end
      end
      ACT_MOVE: begin
        if (same) begin
          case (phase_r)
            PH_PRESSED: begin
              if (past_thr) begin
                phase_nxt    = PH_DRAGGING;
                capture_last = 1'b1;
                res_vld      = 1'b1;
                kind         = GP_STARTED;
              end
            end
            PH_DRAGGING: begin
              capture_last = 1'b1;
              res_vld      = 1'b1;
              kind         = GP_UPDATED;
            end
            default: ;
          endcase
        end
      end
      ACT_RELEASE: begin
        if (same && (phase_r == PH_PRESSED || phase_r == PH_DRAGGING)) begin
          phase_nxt = PH_IDLE;
          res_vld   = 1'b1;
          kind      = GP_FINISHED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      thr_r      <= THRESHOLD_RST;
      track_id_r <= '0;
      start_x_r  <= '0;
      start_y_r  <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r <= phase_nxt;
        if (capture_start) begin
          track_id_r <= item_pointer_id;
          start_x_r  <= item_pos_x;
          start_y_r  <= item_pos_y;
        end
        if (capture_last) begin
          last_x_r <= item_pos_x;
          last_y_r <= item_pos_y;
        end
      end
    end
  end

  assign res_phase   = kind;
  assign res_start_x = start_x_r;
  assign res_start_y = start_y_r;
  assign res_cur_x   = (kind == GP_FINISHED) ? last_x_r : item_pos_x;
  assign res_cur_y   = (kind == GP_FINISHED) ? last_y_r : item_pos_y;
  assign res_delta_x = (kind == GP_STARTED) ? '0 : dl_x;
  assign res_delta_y = (kind == GP_STARTED) ? '0 : dl_y;

endmodule

/* rtl/core/dgd_out_reg.sv */
// Result register: holds one gesture result until the sink takes it.
module dgd_out_reg
  import dgd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int OUT_TDATA_W = 104
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [GESTURE_PHASE_W-1:0] res_phase,
  input  logic [COORD_WIDTH-1:0]     res_start_x,
  input  logic [COORD_WIDTH-1:0]     res_start_y,
  input  logic [COORD_WIDTH-1:0]     res_cur_x,
  input  logic [COORD_WIDTH-1:0]     res_cur_y,
  input  logic [COORD_WIDTH:0]       res_delta_x,
  input  logic [COORD_WIDTH:0]       res_delta_y,
  output logic                       slot_free,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_TDATA_W-1:0]     out_tdata
);

  localparam int OUT_BITS = GESTURE_PHASE_W + 4 * COORD_WIDTH + 2 * (COORD_WIDTH + 1);

  logic                vld_r, vld_nxt;
  logic [OUT_BITS-1:0] data_r;

  assign slot_free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {res_delta_y, res_delta_x, res_cur_y, res_cur_x,
                 res_start_y, res_start_x, res_phase};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = OUT_TDATA_W'(data_r);

endmodule

/* bench/tb_drag_gesture_detector.sv */
// Testbench for drag_gesture_detector: directed and random pointer events checked by a scoreboard.
module tb_drag_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import dgd_pkg::*;

  localparam int CW       = COORD_WIDTH_DEF;
  localparam int PW       = POINTER_ID_WIDTH_DEF;
  localparam int DW       = CW + 1;
  localparam int IN_BITS  = ACTION_W + BUTTON_W + PW + 2 * CW;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = GESTURE_PHASE_W + 4 * CW + 2 * DW;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // action code the block has no meaning for
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_MAX = 17'd131070;

  // two register stages plus margin, for requests that give no result
  localparam int DRAIN_CYCLES   = 4;
  // cycles with no request moving on either side before giving up
  localparam int WATCHDOG_LIMIT = 2000;

  // request layout, lowest field last
  typedef struct packed {
    logic [IN_W-IN_BITS-1:0] pad;
    logic signed [CW-1:0]    pos_y;
    logic signed [CW-1:0]    pos_x;
    logic [PW-1:0]           pointer_id;
    logic [BUTTON_W-1:0]     button;
    logic [ACTION_W-1:0]     action;
  } ptr_event_t;

  // result layout, lowest field last
  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0]  pad;
    logic signed [DW-1:0]       delta_y;
    logic signed [DW-1:0]       delta_x;
    logic signed [CW-1:0]       cur_y;
    logic signed [CW-1:0]       cur_x;
    logic signed [CW-1:0]       start_y;
    logic signed [CW-1:0]       start_x;
    logic [GESTURE_PHASE_W-1:0] gesture;
  } gesture_beat_t;

  // Tracks the drag state of the block and holds the gestures still owed.
  class drag_scoreboard;
    logic [THRESHOLD_W-1:0] threshold;
    phase_t                 phase;
    logic [PW-1:0]          tracked;
    logic signed [CW-1:0]   start_x, start_y, last_x, last_y;
    gesture_beat_t          pending_gestures[$];
    int                     errors;

    function new();
      threshold = THRESHOLD_RST;
      phase     = PH_IDLE;
      tracked   = '0;
      start_x   = '0;
      start_y   = '0;
      last_x    = '0;
      last_y    = '0;
      errors    = 0;
    endfunction

    function void note_event(input ptr_event_t ev);
      gesture_beat_t g;
      int dx, dy;
      g = '0;
      if (ev.action == ACT_PRESS) begin
        if (phase == PH_IDLE && ev.button == BUTTON_LEFT) begin
          phase   = PH_PRESSED;
          tracked = ev.pointer_id;
          start_x = ev.pos_x;
          start_y = ev.pos_y;
          last_x  = ev.pos_x;
          last_y  = ev.pos_y;
        end
      end else if ((ev.action == ACT_MOVE || ev.action == ACT_RELEASE) &&
                   phase != PH_IDLE && ev.pointer_id == tracked) begin
        g.start_x = start_x;
        g.start_y = start_y;
        if (ev.action == ACT_RELEASE) begin
          // delta from the last tracked position, which stays put
          dx        = int'(ev.pos_x) - int'(last_x);
          dy        = int'(ev.pos_y) - int'(last_y);
          g.gesture = GP_FINISHED;
          g.cur_x   = last_x;
          g.cur_y   = last_y;
          g.delta_x = dx[DW-1:0];
          g.delta_y = dy[DW-1:0];
          phase     = PH_IDLE;
          pending_gestures = {pending_gestures, g};
        end else if (phase == PH_DRAGGING) begin
          dx        = int'(ev.pos_x) - int'(last_x);
          dy        = int'(ev.pos_y) - int'(last_y);
          g.gesture = GP_UPDATED;
          g.cur_x   = ev.pos_x;
          g.cur_y   = ev.pos_y;
          g.delta_x = dx[DW-1:0];
          g.delta_y = dy[DW-1:0];
          last_x    = ev.pos_x;
          last_y    = ev.pos_y;
          pending_gestures = {pending_gestures, g};
        end else begin
          dx = int'(ev.pos_x) - int'(start_x);
          dy = int'(ev.pos_y) - int'(start_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dx + dy > int'(threshold)) begin
            phase     = PH_DRAGGING;
            last_x    = ev.pos_x;
            last_y    = ev.pos_y;
            g.gesture = GP_STARTED;
            g.cur_x   = ev.pos_x;
            g.cur_y   = ev.pos_y;
            pending_gestures = {pending_gestures, g};
          end
        end
      end
    endfunction

    function void compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_gesture(input gesture_beat_t got);
      gesture_beat_t want;
      if (pending_gestures.size() == 0) begin
        $display("%0t: unexpected gesture, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = pending_gestures.pop_front();
      compare_field("gesture_phase", want.gesture, got.gesture);
      compare_field("start_x", want.start_x, got.start_x);
      compare_field("start_y", want.start_y, got.start_y);
      compare_field("cur_x", want.cur_x, got.cur_x);
      compare_field("cur_y", want.cur_y, got.cur_y);
      compare_field("delta_x", want.delta_x, got.delta_x);
      compare_field("delta_y", want.delta_y, got.delta_y);
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_W-1:0]       out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [THRESHOLD_W-1:0] cfg_wr_data = '0;

  drag_scoreboard sb;
  int             sent        = 0;     // requests accepted so far
  int             idle_cycles = 0;     // cycles since the last request moved
  bit             burst       = 1'b0;  // no idling on either side while set
  bit             timed_out   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  drag_gesture_detector #(
    .COORD_WIDTH      (CW),
    .POINTER_ID_WIDTH (PW)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // action, button, pointer_id, pos_x, pos_y; zero padded
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // gesture_phase, start_x, start_y, cur_x, cur_y,
                                // delta_x, delta_y; zero padded
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Result side stalls about 12 percent of the time, never during a burst.
  always @(negedge clk) begin
    out_tready <= burst || ($urandom_range(0, 99) >= 12);
  end

  // Both sides sampled at the rising edge. Requests are noted before results
  // so that an accepted event is always predicted ahead of its gesture.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) sb.note_event(in_tdata);
      if (out_tvalid && out_tready) sb.check_gesture(out_tdata);
      idle_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                     0 : idle_cycles + 1;
    end
  end

  function automatic ptr_event_t ev_of(input logic [ACTION_W-1:0] action,
                                       input logic [BUTTON_W-1:0] button,
                                       input logic [PW-1:0] pid,
                                       input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
    ptr_event_t ev;
    ev            = '0;
    ev.action     = action;
    ev.button     = button;
    ev.pointer_id = pid;
    ev.pos_x      = x;
    ev.pos_y      = y;
    return ev;
  endfunction

  // Any field, any value: stray pointers, odd buttons, the unused code.
  function automatic ptr_event_t random_noise();
    return ev_of(ACTION_W'($urandom_range(0, 3)), BUTTON_W'($urandom), PW'($urandom),
                 CW'($urandom), CW'($urandom));
  endfunction

  // Small step around a position, now and then a jump anywhere; wraps freely.
  function automatic logic signed [CW-1:0] nudge(input logic signed [CW-1:0] p,
                                                 input int span);
    if ($urandom_range(0, 9) == 0) return CW'($urandom);
    return p + CW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so the next call may keep it high.
  task automatic send_event(input ptr_event_t ev);
    while (!burst && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ev;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Stop sending, wait for every owed gesture, then let silent requests drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_gestures.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [THRESHOLD_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    sb.threshold = value;
  endtask

  // Press, a handful of moves with noise in between, usually a release.
  task automatic random_drag();
    logic [PW-1:0]        pid;
    logic signed [CW-1:0] x, y;
    int                   span;
    pid  = PW'($urandom);
    x    = CW'($urandom);
    y    = CW'($urandom);
    span = int'(sb.threshold) / 3 + 4;
    if (span > 20000) span = 20000;
    send_event(ev_of(ACT_PRESS, BUTTON_LEFT, pid, x, y));
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 4) == 0) send_event(random_noise());
      x = nudge(x, span);
      y = nudge(y, span);
      send_event(ev_of(ACT_MOVE, BUTTON_W'($urandom), pid, x, y));
    end
    if ($urandom_range(0, 7) != 0)
      send_event(ev_of(ACT_RELEASE, BUTTON_W'($urandom), pid, nudge(x, span),
                       nudge(y, span)));
  endtask

  initial begin
    logic [THRESHOLD_W-1:0] th;
    int                     quota;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      begin
        // Directed, reset threshold of 25.
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd0, 16'sd50, 16'sd50));      // idle move
        send_event(ev_of(ACT_RELEASE, BUTTON_LEFT, 4'd0, 16'sd50, 16'sd50));   // idle release
        send_event(ev_of(ACT_UNUSED, BUTTON_LEFT, 4'd0, 16'sd50, 16'sd50));
        send_event(ev_of(ACT_PRESS, 3'd3, 4'd5, 16'sd100, 16'sd100));         // not left
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd5, 16'sd100, 16'sd100));
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd9, 16'sd0, 16'sd0));       // not idle
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd6, 16'sd5000, 16'sd5000));  // other pointer
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd5, 16'sd110, 16'sd115));    // exactly 25
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd5, 16'sd110, 16'sd116));    // starts
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd5, -16'sd32768, 16'sd32767));
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd5, 16'sd32767, -16'sd32768));
        send_event(ev_of(ACT_RELEASE, BUTTON_LEFT, 4'd4, 16'sd0, 16'sd0));     // other pointer
        send_event(ev_of(ACT_RELEASE, 3'd7, 4'd5, 16'sd0, 16'sd0));
        // release straight from pressed: delta taken from the start
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd15, -16'sd32768, -16'sd32768));
        send_event(ev_of(ACT_RELEASE, BUTTON_LEFT, 4'd15, 16'sd32767, 16'sd32767));
        // button ignored on move and release
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd0, 16'sd0, 16'sd0));
        send_event(ev_of(ACT_MOVE, 3'd7, 4'd0, 16'sd20, 16'sd6));
        send_event(ev_of(ACT_RELEASE, 3'd7, 4'd0, 16'sd20, 16'sd6));

        // Corner to corner only just clears the largest usable threshold.
        set_threshold(THRESHOLD_MAX - 17'd1);
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd3, -16'sd32768, -16'sd32768));
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd3, 16'sd32767, 16'sd32767));
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd3, -16'sd32768, -16'sd32768));
        send_event(ev_of(ACT_RELEASE, BUTTON_LEFT, 4'd3, -16'sd32768, -16'sd32768));
        // ...and at the maximum no drag can ever start
        set_threshold(THRESHOLD_MAX);
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd3, -16'sd32768, -16'sd32768));
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd3, 16'sd32767, 16'sd32767));
        send_event(ev_of(ACT_RELEASE, BUTTON_LEFT, 4'd3, 16'sd32767, 16'sd32767));
        // zero threshold: standing still is not a drag, one pixel is
        set_threshold('0);
        send_event(ev_of(ACT_PRESS, BUTTON_LEFT, 4'd7, 16'sd1, 16'sd1));
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd7, 16'sd1, 16'sd1));
        send_event(ev_of(ACT_MOVE, BUTTON_LEFT, 4'd7, 16'sd1, 16'sd2));
        send_event(ev_of(ACT_RELEASE, BUTTON_LEFT, 4'd7, 16'sd1, 16'sd2));

        // Random phases, each under its own threshold; the high ones are
        // short since hardly any drag gets going there.
        for (int p = 0; p < 8; p++) begin
          case (p)
            0:       th = '0;
            1:       th = THRESHOLD_W'($urandom_range(1, 40));
            2:       th = THRESHOLD_MAX;
            3:       th = THRESHOLD_W'($urandom_range(0, THRESHOLD_MAX));
            4:       th = THRESHOLD_W'($urandom_range(0, 300));
            5:       th = THRESHOLD_RST;
            default: th = THRESHOLD_W'($urandom_range(0, 60));
          endcase
          set_threshold(th);
          burst = (p == 5);
          quota = sent + ((p == 2 || p == 3) ? 100 : 300);
          while (sent < quota) begin
            if ($urandom_range(0, 4) == 0) send_event(random_noise());
            else random_drag();
          end
        end
        burst = 1'b0;
        settle();
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && sb.errors == 0 && sb.pending_gestures.size() == 0)
      $display("tb_drag_gesture_detector: clean");
    else
      $display("tb_drag_gesture_detector: errors");
    $finish;
  end

endmodule
